### rtl/assert_macros.svh
// Assertion helpers for the column decimator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition holds on every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition never holds on a clock outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

### rtl/wcmmr_pkg.sv
package wcmmr_pkg;
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_COLUMNS  = 4096;
    localparam int FRAME_BITS   = 24;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_MONO     = 2'd1;
    localparam logic [1:0] REG_FRAMES   = 2'd2;
    localparam logic [1:0] REG_COLUMNS  = 2'd3;

    localparam logic signed [10:0] HIGH_EMPTY = -11'sd1000;
    localparam logic signed [10:0] LOW_EMPTY  = 11'sd1000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic restart;   // clear accumulators and positions, new stream
        logic accum;     // fold the input item in
        logic div_start; // begin divide of channel sum
        logic div_step;
        logic sq_start;
        logic sq_step;
        logic emit;      // load output register
        logic next_col;  // clear accumulators, next column
        logic bnd_start; // begin boundary division
        logic bnd_step;
    } t_cmd;

    typedef struct packed {
        logic frame_done;
        logic col_end;
        logic last_col;
        logic last_ch;
    } t_stat;
endpackage

### rtl/wcmmr_datapath.sv
module wcmmr_datapath (
    input  logic                   i_clk,
    input  wcmmr_pkg::t_cmd        i_cmd,
    input  logic [3:0]             i_chan_cfg,
    input  logic                   i_mono,
    input  logic [23:0]            i_frames_cfg,
    input  logic [12:0]            i_cols_cfg,
    input  logic [10:0]            i_high,
    input  logic [10:0]            i_low,
    input  logic [10:0]            i_rms,
    output wcmmr_pkg::t_stat       o_stat,
    output logic [5:0]             o_cnt,
    output logic [11:0]            o_col,
    output logic [2:0]             o_ch,
    output logic signed [10:0]     o_col_high,
    output logic signed [10:0]     o_col_low,
    output logic [9:0]             o_col_rms,
    output logic                   o_col_empty,
    output logic                   o_last
);
    localparam int MAX_CHANNELS = wcmmr_pkg::MAX_CHANNELS;
    localparam int MAX_COLUMNS  = wcmmr_pkg::MAX_COLUMNS;
    localparam int FRAME_BITS   = wcmmr_pkg::FRAME_BITS;
    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int COLW = $clog2(MAX_COLUMNS + 1);
    localparam int NUMW = FRAME_BITS + COLW;
    localparam int SUMW = 48;
    localparam int CNTW = 28;
    localparam logic signed [10:0] HIGH_E = wcmmr_pkg::HIGH_EMPTY;
    localparam logic signed [10:0] LOW_E  = wcmmr_pkg::LOW_EMPTY;

    logic signed [10:0] r_hi [MAX_CHANNELS];
    logic signed [10:0] r_lo [MAX_CHANNELS];
    logic [SUMW-1:0]    r_sum [MAX_CHANNELS];
    logic [CNTW-1:0]    r_count;
    logic [CHW-1:0]     r_chpos;
    logic [CHW-1:0]     r_k;
    logic [FRAME_BITS-1:0] r_fpos;
    logic [11:0]        r_colnum;
    logic [NUMW-1:0]    r_bnum;
    // boundary divider
    logic [NUMW-1:0]    r_bq;
    logic [NUMW-1:0]    r_brem;
    logic [FRAME_BITS-1:0] r_end;
    // mean divider and root
    logic [SUMW-1:0]    r_dq;
    logic [CNTW:0]      r_drem;
    logic [SUMW-1:0]    r_sv;
    logic [SUMW-1:0]    r_sr;
    logic [5:0]         r_cnt;

    logic [4:0]            nch;
    logic [FRAME_BITS-1:0] ef;
    logic [COLW-1:0]       ec;
    logic [CHW-1:0]        ch, slot;
    logic [FRAME_BITS-1:0] fpos_inc;
    logic [NUMW:0]         b_try;
    logic [CNTW+1:0]       d_try;
    logic [SUMW-1:0]       sbit, s_try;
    logic signed [21:0]    sq;

    always_comb begin
        nch = (i_chan_cfg == 4'd0) ? 5'd1 : {1'b0, i_chan_cfg};
        if (nch > 5'(MAX_CHANNELS)) nch = 5'(MAX_CHANNELS);
        ef = (i_frames_cfg[FRAME_BITS-1:0] == '0) ? FRAME_BITS'(1)
                                                  : i_frames_cfg[FRAME_BITS-1:0];
        ec = (i_cols_cfg == 13'd0) ? COLW'(1) : COLW'(i_cols_cfg);
        if (ec > COLW'(MAX_COLUMNS)) ec = COLW'(MAX_COLUMNS);
        if ({{FRAME_BITS{1'b0}}, ec} > {{COLW{1'b0}}, ef}) ec = COLW'(ef);
        ch = (5'(r_chpos) >= nch) ? '0 : r_chpos;
        slot = i_mono ? '0 : ch;
        sq = $signed(i_rms) * $signed(i_rms);
        fpos_inc = r_fpos + 1'b1;
        b_try = {r_brem, r_bq[NUMW-1]} - {1'b0, {FRAME_BITS{1'b0}}, ec};
        d_try = {r_drem, r_dq[SUMW-1]} - {2'b0, r_count};
        sbit = SUMW'(1) << (2 * (r_cnt[4:0]));
        s_try = r_sr + sbit;
    end

    assign o_stat.frame_done = (5'(ch) + 5'd1 >= nch);
    assign o_stat.col_end  = (r_fpos >= ((r_end == '0) ? FRAME_BITS'(1) : r_end));
    assign o_stat.last_col = ({1'b0, r_colnum} + 13'd1 >= 13'(ec));
    assign o_stat.last_ch  = i_mono || (5'(r_k) + 5'd1 >= nch);
    assign o_cnt = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.restart || i_cmd.next_col) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_hi[i]  <= HIGH_E;
                r_lo[i]  <= LOW_E;
                r_sum[i] <= '0;
            end
            r_count <= '0;
            r_k     <= '0;
            r_chpos <= '0;
            if (i_cmd.restart) begin
                r_fpos   <= '0;
                r_colnum <= '0;
                r_bnum   <= NUMW'(ef);
            end else begin
                r_colnum <= r_colnum + 1'b1;
                r_bnum   <= r_bnum + NUMW'(ef);
            end
        end else if (i_cmd.accum) begin
            if ($signed(i_high) > r_hi[slot]) r_hi[slot] <= i_high;
            if ($signed(i_low) < r_lo[slot]) r_lo[slot] <= i_low;
            r_sum[slot] <= r_sum[slot] + SUMW'(unsigned'(sq));
            if (o_stat.frame_done) begin
                r_chpos <= '0;
                r_count <= r_count + (i_mono ? CNTW'(nch) : CNTW'(1));
                r_fpos  <= fpos_inc;
            end else begin
                r_chpos <= ch + 1'b1;
            end
        end
        // boundary = bnum / ec, one bit per cycle
        if (i_cmd.bnd_start) begin
            r_bq   <= r_bnum;
            r_brem <= '0;
            r_cnt  <= 6'(NUMW);
        end else if (i_cmd.bnd_step) begin
            if (!b_try[NUMW]) begin
                r_brem <= b_try[NUMW-1:0];
                r_bq   <= {r_bq[NUMW-2:0], 1'b1};
            end else begin
                r_brem <= {r_brem[NUMW-2:0], r_bq[NUMW-1]};
                r_bq   <= {r_bq[NUMW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == 6'd1) r_end <= (b_try[NUMW]) ?
                FRAME_BITS'({r_bq[NUMW-2:0], 1'b0}) : FRAME_BITS'({r_bq[NUMW-2:0], 1'b1});
        end
        // mean = sum / count, one bit per cycle
        if (i_cmd.div_start) begin
            r_dq   <= r_sum[r_k];
            r_drem <= '0;
            r_cnt  <= 6'(SUMW);
        end else if (i_cmd.div_step) begin
            if (!d_try[CNTW+1]) begin
                r_drem <= d_try[CNTW:0];
                r_dq   <= {r_dq[SUMW-2:0], 1'b1};
            end else begin
                r_drem <= {r_drem[CNTW-1:0], r_dq[SUMW-1]};
                r_dq   <= {r_dq[SUMW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
        // root, two bits per cycle, 24 steps
        if (i_cmd.sq_start) begin
            r_sv  <= r_dq;
            r_sr  <= '0;
            r_cnt <= 6'd23;
        end else if (i_cmd.sq_step) begin
            if (r_sv >= s_try) begin
                r_sv <= r_sv - s_try;
                r_sr <= (r_sr >> 1) + sbit;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_cnt <= r_cnt - 1'b1;
        end
        // load result register
        if (i_cmd.emit) begin
            o_col       <= r_colnum;
            o_ch        <= 3'(r_k);
            o_col_empty <= (r_count == '0);
            o_col_high  <= (r_count == '0) ? HIGH_E : r_hi[r_k];
            o_col_low   <= (r_count == '0) ? LOW_E : r_lo[r_k];
            o_col_rms   <= (r_count == '0) ? 10'd0 :
                           (r_sr > SUMW'(1023)) ? 10'd1023 : r_sr[9:0];
            o_last      <= o_stat.last_ch;
            r_k         <= r_k + 1'b1;
        end
    end
endmodule

### rtl/wcmmr_ctrl.sv
module wcmmr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic              i_in_go,
    input  logic              i_out_take,
    input  wcmmr_pkg::t_stat  i_stat,
    input  logic [5:0]        i_cnt,
    output wcmmr_pkg::t_cmd   o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    typedef enum logic [3:0] {
        ST_RESTART, ST_BND0, ST_BND, ST_IDLE, ST_CHECK,
        ST_DIV0, ST_DIV, ST_SQ0, ST_SQ, ST_EMIT, ST_WAIT, ST_NEXT
    } t_state;

    t_state r_state;
    logic   r_last;

    always_comb begin
        o_cmd = '0;
        o_cmd.restart   = (r_state == ST_RESTART);
        o_cmd.bnd_start = (r_state == ST_BND0);
        o_cmd.bnd_step  = (r_state == ST_BND);
        o_cmd.accum     = (r_state == ST_IDLE) && i_in_go;
        o_cmd.div_start = (r_state == ST_DIV0);
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.sq_start  = (r_state == ST_SQ0);
        o_cmd.sq_step   = (r_state == ST_SQ);
        o_cmd.emit      = (r_state == ST_EMIT);
        o_cmd.next_col  = (r_state == ST_NEXT) && !r_last;
        o_in_ready = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_state     <= ST_RESTART;
            o_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            // raise valid on load, drop it once the transaction is taken
            if (r_state == ST_EMIT) o_out_valid <= 1'b1;
            else if (i_out_take) o_out_valid <= 1'b0;
            unique case (r_state)
                ST_RESTART: r_state <= ST_BND0;
                ST_BND0:    r_state <= ST_BND;
                ST_BND:     if (i_cnt == 6'd1) r_state <= ST_IDLE;
                ST_IDLE:    if (i_in_go && i_stat.frame_done) r_state <= ST_CHECK;
                ST_CHECK:   r_state <= i_stat.col_end ? ST_DIV0 : ST_IDLE;
                ST_DIV0:    r_state <= ST_DIV;
                ST_DIV:     if (i_cnt == 6'd1) r_state <= ST_SQ0;
                ST_SQ0:     r_state <= ST_SQ;
                ST_SQ:      if (i_cnt == 6'd0) r_state <= ST_WAIT;
                ST_WAIT:    if (!o_out_valid || i_out_take) r_state <= ST_EMIT;
                ST_EMIT: begin
                    r_last      <= i_stat.last_col;
                    r_state     <= i_stat.last_ch ? ST_NEXT : ST_DIV0;
                end
                ST_NEXT:    r_state <= r_last ? ST_RESTART : ST_BND0;
                default:    r_state <= ST_RESTART;
            endcase
        end
    end
endmodule

### rtl/waveform_column_min_max_rms.sv
// A transaction that closes a column gives its first result after the check state, mean divider,
// root, output wait and load. Input is taken only in the idle state, which mid-frame transactions
// do not leave; a frame end passes the check state, and a column end adds divider, root, output
// wait and load per result, then boundary division, led by a restart after the last column.
// Reset is synchronous, active low; it and any register write restart at frame 0, column 0
// and run the boundary division before input is accepted.
`include "assert_macros.svh"
module waveform_column_min_max_rms (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // peak_high, peak_low, rms_value, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // column_index, channel_index, column_high,
                                       // column_low, column_rms, column_empty
    output logic        m_axis_tlast
);
    logic [3:0]  r_chan;
    logic        r_mono;
    logic [23:0] r_frames;
    logic [12:0] r_cols;
    logic        cfg_wr;
    wcmmr_pkg::t_cmd  cmd;
    wcmmr_pkg::t_stat stat;
    logic [5:0]  cnt;
    logic [11:0] col;
    logic [2:0]  chn;
    logic signed [10:0] hi, lo;
    logic [9:0]  rms;
    logic        empty;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= 4'd2; r_mono <= 1'b0; r_frames <= 24'd1; r_cols <= 13'd1;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                wcmmr_pkg::REG_CHANNELS: r_chan   <= i_cfg_data[3:0];
                wcmmr_pkg::REG_MONO:     r_mono   <= i_cfg_data[0];
                wcmmr_pkg::REG_FRAMES:   r_frames <= i_cfg_data;
                wcmmr_pkg::REG_COLUMNS:  r_cols   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    wcmmr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr(cfg_wr),
        .i_in_go(s_axis_tvalid && s_axis_tready),
        .i_out_take(m_axis_tvalid && m_axis_tready),
        .i_stat(stat), .i_cnt(cnt), .o_cmd(cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    wcmmr_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_chan_cfg(r_chan), .i_mono(r_mono),
        .i_frames_cfg(r_frames), .i_cols_cfg(r_cols),
        .i_high(s_axis_tdata[10:0]), .i_low(s_axis_tdata[21:11]),
        .i_rms(s_axis_tdata[32:22]), .o_stat(stat), .o_cnt(cnt),
        .o_col(col), .o_ch(chn), .o_col_high(hi), .o_col_low(lo),
        .o_col_rms(rms), .o_col_empty(empty), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {empty, rms, lo, hi, chn, col};

    `ASSERT_NEVER(a_in_emit, i_clk, i_rst_n, s_axis_tready && cmd.emit, "ready during emit")
    `ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, $onehot0(cmd), "conflicting datapath commands")
endmodule
